[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted
`define QTK_ASSERT_RST(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("qtk assertion failed");

// Concurrent assertion that is also checked during reset
`define QTK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("qtk assertion failed");

`endif

[src/qtk_pkg.sv]
// Package: types, tables and constants of the quadrature tuning knob
package qtk_pkg;

  localparam int unsigned FreqW     = 29;
  localparam int unsigned StepSelW  = 2;
  localparam int unsigned StepHzW   = 17;
  localparam int unsigned NumSteps  = 4;
  localparam int unsigned CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBandLow  = 1'b0,
    CfgBandHigh = 1'b1
  } cfg_idx_e;

  localparam logic [FreqW-1:0] BandLowRst  = FreqW'(14000000);
  localparam logic [FreqW-1:0] BandHighRst = FreqW'(14350000);
  localparam logic [FreqW-1:0] FreqRst     = FreqW'(14074000);
  localparam logic [1:0]       PrevAbRst   = 2'b11;
  localparam logic [StepSelW-1:0] StepSelRst = StepSelW'(1);

  typedef logic signed [1:0] delta_t;

  // index is {prev_a, prev_b, cur_a, cur_b}
  localparam delta_t QuadTable [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

  localparam logic [StepHzW-1:0] StepHz [4] = '{
    StepHzW'(100), StepHzW'(1000), StepHzW'(10000), StepHzW'(100000)
  };

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic button_level;
  } sample_t;

  typedef struct packed {
    logic [FreqW-1:0]    tuned_hz;
    logic [StepSelW-1:0] step_index;
    logic                freq_changed;
    logic                step_changed;
  } result_t;

endpackage

[src/qtk_in_if.sv]
// Input channel: one encoder and button sample per transfer
interface qtk_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic button_level;

  modport source (output valid, output pin_a, output pin_b, output button_level,
                  input ready);
  modport sink   (input valid, input pin_a, input pin_b, input button_level,
                  output ready);
endinterface

[src/qtk_out_if.sv]
// Output channel: tuning result per transfer
interface qtk_out_if;
  logic                             valid;
  logic                             ready;
  logic [qtk_pkg::FreqW-1:0]        tuned_hz;
  logic [qtk_pkg::StepSelW-1:0]     step_index;
  logic                             freq_changed;
  logic                             step_changed;

  modport source (output valid, output tuned_hz, output step_index,
                  output freq_changed, output step_changed, input ready);
  modport sink   (input valid, input tuned_hz, input step_index,
                  input freq_changed, input step_changed, output ready);
endinterface

[src/qtk_core.sv]
// Knob state and single-pass decode: button edge, quadrature table, add and clamp
module qtk_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  qtk_pkg::sample_t            sample_i,
  input  logic [qtk_pkg::FreqW-1:0]   band_low_i,
  input  logic [qtk_pkg::FreqW-1:0]   band_high_i,
  output qtk_pkg::result_t            result_o
);

  logic [1:0]                     prev_ab_q, prev_ab_d;
  logic                           prev_btn_q, prev_btn_d;
  logic [qtk_pkg::StepSelW-1:0]   step_sel_q, step_sel_d;
  logic [qtk_pkg::FreqW-1:0]      freq_q, freq_d;

  logic                           press;
  logic [3:0]                     step_inc;
  qtk_pkg::delta_t                delta;
  logic                           detent;
  logic [qtk_pkg::StepHzW-1:0]    step_hz;
  logic signed [30:0]             sum_s;
  logic signed [30:0]             low_s;
  logic signed [30:0]             high_s;
  logic signed [30:0]             clamp_s;

  always_comb begin
    press    = prev_btn_q & ~sample_i.button_level;
    step_inc = {2'b00, step_sel_q} + 4'd1;
    step_sel_d = step_sel_q;
    if (press) begin
      // wrap modulo the number of step sizes
      step_sel_d = (step_inc >= 4'(qtk_pkg::NumSteps)) ? '0 : step_inc[1:0];
    end
    prev_btn_d = sample_i.button_level;
    prev_ab_d  = {sample_i.pin_a, sample_i.pin_b};

    delta   = qtk_pkg::QuadTable[{prev_ab_q, sample_i.pin_a, sample_i.pin_b}];
    detent  = (delta != 2'sd0);
    step_hz = qtk_pkg::StepHz[step_sel_d];

    if (delta[1]) begin
      sum_s = $signed({2'b00, freq_q}) - $signed({14'd0, step_hz});
    end else begin
      sum_s = $signed({2'b00, freq_q}) + $signed({14'd0, step_hz});
    end
    low_s  = $signed({2'b00, band_low_i});
    high_s = $signed({2'b00, band_high_i});
    // raise to the low limit first, then lower to the high limit
    clamp_s = (sum_s < low_s) ? low_s : sum_s;
    if (clamp_s > high_s) begin
      clamp_s = high_s;
    end
    freq_d = detent ? clamp_s[qtk_pkg::FreqW-1:0] : freq_q;

    result_o.tuned_hz     = freq_d;
    result_o.step_index   = step_sel_d;
    result_o.freq_changed = detent;
    result_o.step_changed = press;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q  <= qtk_pkg::PrevAbRst;
      prev_btn_q <= 1'b1;
      step_sel_q <= qtk_pkg::StepSelRst;
      freq_q     <= qtk_pkg::FreqRst;
    end else if (advance_i) begin
      prev_ab_q  <= prev_ab_d;
      prev_btn_q <= prev_btn_d;
      step_sel_q <= step_sel_d;
      freq_q     <= freq_d;
    end
  end

endmodule

[src/quadrature_tuning_knob_unit.sv]
// Top level: sample register, knob core, result register and band registers
//
//   channel   dir   transfer when          payload
//   in_i      in    valid & ready          pin_a, pin_b, button_level
//   out_o     out   valid & ready          tuned_hz, step_index, freq_changed, step_changed
//   cfg       in    cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One sample per cycle while out_o takes its results; a result passes through the sample register,
// then the result register, with decode/add/clamp in between.
// The result register and sample register stall together while out_o is not taken;
// in_i stays ready as long as the result register can move on.
// Reset restores the knob state and the band limits.
module quadrature_tuning_knob_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  qtk_in_if.sink                            in_i,
  qtk_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [qtk_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [qtk_pkg::FreqW-1:0]         cfg_wdata_i
);

  logic                         smp_valid_q;
  qtk_pkg::sample_t             smp_q;
  logic                         res_valid_q;
  qtk_pkg::result_t             res_q;
  qtk_pkg::result_t             res_d;
  logic [qtk_pkg::FreqW-1:0]    band_low_q;
  logic [qtk_pkg::FreqW-1:0]    band_high_q;
  logic                         res_free;
  logic                         advance;
  logic                         in_fire;

  assign res_free  = ~res_valid_q | out_o.ready;
  assign advance   = smp_valid_q & res_free;
  assign in_i.ready = ~smp_valid_q | res_free;
  assign in_fire   = in_i.valid & in_i.ready;

  qtk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .sample_i    (smp_q),
    .band_low_i  (band_low_q),
    .band_high_i (band_high_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      band_low_q  <= qtk_pkg::BandLowRst;
      band_high_q <= qtk_pkg::BandHighRst;
    end else begin
      if (in_i.ready) begin
        smp_valid_q <= in_i.valid;
      end
      if (res_free) begin
        res_valid_q <= smp_valid_q;
      end
      if (cfg_we_i) begin
        case (qtk_pkg::cfg_idx_e'(cfg_idx_i))
          qtk_pkg::CfgBandLow:  band_low_q  <= cfg_wdata_i;
          qtk_pkg::CfgBandHigh: band_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= '{pin_a: in_i.pin_a, pin_b: in_i.pin_b,
                 button_level: in_i.button_level};
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.tuned_hz     = res_q.tuned_hz;
  assign out_o.step_index   = res_q.step_index;
  assign out_o.freq_changed = res_q.freq_changed;
  assign out_o.step_changed = res_q.step_changed;

endmodule

[src/qtk_checker.sv]
// Port-level checker for the tuning knob, bound to the top level
`include "assert_macros.svh"

module qtk_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [qtk_pkg::FreqW-1:0]       tuned_hz_i,
  input logic [qtk_pkg::StepSelW-1:0]    step_index_i,
  input logic                            freq_changed_i,
  input logic                            step_changed_i
);

  logic                          seen_q;
  logic [qtk_pkg::FreqW-1:0]     last_hz_q;
  logic [qtk_pkg::StepSelW-1:0]  last_step_q;
  logic                          out_fire;

  assign out_fire = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_hz_q   <= '0;
      last_step_q <= '0;
    end else if (out_fire) begin
      seen_q      <= 1'b1;
      last_hz_q   <= tuned_hz_i;
      last_step_q <= step_index_i;
    end
  end

  `QTK_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_i)

  `QTK_ASSERT_RST(a_stall_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(tuned_hz_i) && $stable(step_index_i))

  `QTK_ASSERT_RST(a_idle_ready, clk_i, rst_ni, !out_valid_i |-> in_ready_i)

  `QTK_ASSERT_RST(a_freq_kept, clk_i, rst_ni, out_fire && seen_q && !freq_changed_i |-> tuned_hz_i == last_hz_q)

  `QTK_ASSERT_RST(a_step_kept, clk_i, rst_ni, out_fire && seen_q && !step_changed_i |-> step_index_i == last_step_q)

endmodule

bind quadrature_tuning_knob_unit qtk_checker u_qtk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .tuned_hz_i     (out_o.tuned_hz),
  .step_index_i   (out_o.step_index),
  .freq_changed_i (out_o.freq_changed),
  .step_changed_i (out_o.step_changed)
);

[tb/tb_top.sv]
// Testbench for quadrature_tuning_knob_unit: directed and random knob samples, self-checking
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // direction per {prev_ab, cur_ab}; +1 follows the sequence 00 -> 10 -> 11 -> 01
  localparam int QuadDir [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam int StepSizeHz [4] = '{100, 1000, 10000, 100000};
  localparam logic [1:0] KnobSeq [4] = '{2'b00, 2'b10, 2'b11, 2'b01};
  localparam logic [1:0] WalkAb [13] = '{
    2'b01, 2'b00, 2'b10, 2'b11, 2'b10, 2'b00, 2'b01, 2'b11,
    2'b00, 2'b11, 2'b01, 2'b10, 2'b01
  };
  localparam logic [qtk_pkg::FreqW-1:0] FreqMax = '1;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [qtk_pkg::CfgIdxW-1:0] cfg_idx;
  logic [qtk_pkg::FreqW-1:0] cfg_wdata;

  qtk_in_if  in_if ();
  qtk_out_if out_if ();

  quadrature_tuning_knob_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // knob state as the block should hold it
  logic [qtk_pkg::FreqW-1:0]    model_hz;
  logic [qtk_pkg::StepSelW-1:0] model_step;
  logic [1:0]                   model_ab;
  logic                         model_btn;
  logic [qtk_pkg::FreqW-1:0]    band_lo_hz;
  logic [qtk_pkg::FreqW-1:0]    band_hi_hz;

  qtk_pkg::result_t expected_tuning_q [$];
  qtk_pkg::result_t due_r;
  int      err_cnt = 0;
  int      in_gap_pct = 0;
  int      out_stall_pct = 0;
  logic [1:0] last_ab;
  logic    last_btn;
  int      spin_dir = 1;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic qtk_pkg::result_t advance_knob(input qtk_pkg::sample_t s);
    qtk_pkg::result_t r;
    logic [1:0] cur_ab;
    int         dir;
    longint     sum;
    cur_ab = {s.pin_a, s.pin_b};
    r.step_changed = 1'b0;
    r.freq_changed = 1'b0;
    // button edge first, so a detent in the same sample uses the new step
    if (model_btn && !s.button_level) begin
      model_step = model_step + 1'b1;
      r.step_changed = 1'b1;
    end
    model_btn = s.button_level;
    dir = QuadDir[{model_ab, cur_ab}];
    model_ab = cur_ab;
    if (dir != 0) begin
      sum = longint'(model_hz) + longint'(dir * StepSizeHz[model_step]);
      if (sum < longint'(band_lo_hz)) sum = longint'(band_lo_hz);
      if (sum > longint'(band_hi_hz)) sum = longint'(band_hi_hz);
      model_hz = sum[qtk_pkg::FreqW-1:0];
      r.freq_changed = 1'b1;
    end
    r.tuned_hz = model_hz;
    r.step_index = model_step;
    return r;
  endfunction

  function automatic logic [1:0] next_ab(input int dir);
    int pos;
    pos = 0;
    for (int i = 0; i < 4; i++) begin
      if (KnobSeq[i] == last_ab) pos = i;
    end
    return KnobSeq[(pos + dir + 4) % 4];
  endfunction

  // mostly clean rotation in runs, some reversals, rests and jumps
  function automatic qtk_pkg::sample_t roll_knob_sample();
    qtk_pkg::sample_t s;
    int         r;
    logic [1:0] ab;
    if ($urandom_range(99) < 5) spin_dir = -spin_dir;
    r = $urandom_range(99);
    if (r < 70) ab = next_ab(spin_dir);
    else if (r < 82) ab = next_ab(-spin_dir);
    else if (r < 90) ab = last_ab;
    else ab = 2'($urandom_range(3));
    s.pin_a = ab[1];
    s.pin_b = ab[0];
    s.button_level = last_btn ? ($urandom_range(99) >= 8) : ($urandom_range(99) < 40);
    return s;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) flag_error($sformatf("%s: expected %0d, got %0d", name, want, got));
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_tuning_q.size() == 0) begin
        flag_error($sformatf("unexpected result transfer: hz %0d step %0d",
                             out_if.tuned_hz, out_if.step_index));
      end else begin
        due_r = expected_tuning_q.pop_front();
        check_field("tuned_hz", 32'(due_r.tuned_hz), 32'(out_if.tuned_hz));
        check_field("step_index", 32'(due_r.step_index), 32'(out_if.step_index));
        check_field("freq_changed", 32'(due_r.freq_changed), 32'(out_if.freq_changed));
        check_field("step_changed", 32'(due_r.step_changed), 32'(out_if.step_changed));
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid left high
  task automatic send_sample(input logic a, input logic b, input logic btn);
    qtk_pkg::sample_t s;
    s.pin_a = a;
    s.pin_b = b;
    s.button_level = btn;
    while ($urandom_range(99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.pin_a <= a;
    in_if.pin_b <= b;
    in_if.button_level <= btn;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_tuning_q.push_back(advance_knob(s));
    last_ab = {a, b};
    last_btn = btn;
    @(negedge clk_i);
  endtask

  task automatic turn_knob(input int dir, input logic btn);
    logic [1:0] ab;
    ab = next_ab(dir);
    send_sample(ab[1], ab[0], btn);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (expected_tuning_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_band(input qtk_pkg::cfg_idx_e idx,
                            input logic [qtk_pkg::FreqW-1:0] hz);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= hz;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == qtk_pkg::CfgBandLow) band_lo_hz = hz;
    else band_hi_hz = hz;
    @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    send_sample(1'b1, 1'b1, 1'b1);
  endtask

  // all eight legal steps in both directions, then the double-pin jumps
  task automatic test_transitions();
    foreach (WalkAb[i]) send_sample(WalkAb[i][1], WalkAb[i][0], 1'b1);
  endtask

  task automatic test_step_button();
    send_sample(last_ab[1], last_ab[0], 1'b0);
    send_sample(last_ab[1], last_ab[0], 1'b0);
    send_sample(last_ab[1], last_ab[0], 1'b1);
    turn_knob(1, 1'b0);
    send_sample(last_ab[1], last_ab[0], 1'b1);
    repeat (2) begin
      send_sample(last_ab[1], last_ab[0], 1'b0);
      send_sample(last_ab[1], last_ab[0], 1'b1);
    end
  endtask

  task automatic test_band_clamp();
    wait_results_drained();
    write_band(qtk_pkg::CfgBandLow, '0);
    write_band(qtk_pkg::CfgBandHigh, FreqMax);
    turn_knob(1, 1'b1);
    wait_results_drained();
    write_band(qtk_pkg::CfgBandHigh, 29'd50);
    // frequency now above the band: holds until a detent
    send_sample(last_ab[1], last_ab[0], 1'b1);
    turn_knob(1, 1'b1);
    turn_knob(-1, 1'b1);
    wait_results_drained();
    write_band(qtk_pkg::CfgBandLow, 29'd1000);
    write_band(qtk_pkg::CfgBandHigh, 29'd500);
    turn_knob(1, 1'b1);
    wait_results_drained();
    write_band(qtk_pkg::CfgBandLow, FreqMax);
    write_band(qtk_pkg::CfgBandHigh, FreqMax);
    turn_knob(-1, 1'b1);
    turn_knob(1, 1'b1);
  endtask

  task automatic test_random_phase(input int gap_pct, input int stall_pct,
                                   input logic [qtk_pkg::FreqW-1:0] lo,
                                   input logic [qtk_pkg::FreqW-1:0] hi,
                                   input int n_items);
    qtk_pkg::sample_t s;
    bit      calm;
    wait_results_drained();
    write_band(qtk_pkg::CfgBandLow, lo);
    write_band(qtk_pkg::CfgBandHigh, hi);
    for (int i = 0; i < n_items; i++) begin
      calm = ((i / 24) % 3 == 2);
      in_gap_pct = calm ? 0 : gap_pct;
      out_stall_pct = calm ? 0 : stall_pct;
      if (i == n_items / 2) wait_results_drained();
      s = roll_knob_sample();
      send_sample(s.pin_a, s.pin_b, s.button_level);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.pin_a = 1'b1;
    in_if.pin_b = 1'b1;
    in_if.button_level = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = qtk_pkg::CfgBandLow;
    cfg_wdata = '0;
    model_hz = 29'd14074000;
    model_step = 2'd1;
    model_ab = 2'b11;
    model_btn = 1'b1;
    band_lo_hz = 29'd14000000;
    band_hi_hz = 29'd14350000;
    last_ab = 2'b11;
    last_btn = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_transitions();
    test_step_button();
    test_band_clamp();
    test_random_phase(0, 0, '0, 29'd300, 170);
    test_random_phase(56, 0, FreqMax - 29'd250000, FreqMax, 170);
    test_random_phase(0, 56, 29'd1000000, 29'd1400000, 170);
    test_random_phase(12, 12, 29'd14000000, 29'd14350000, 170);

    in_gap_pct = 0;
    out_stall_pct = 0;
    wait_results_drained();
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
